### design/dds_pkg.sv
// Package for the six-digit decimal splitter: types, constants and the
// subtrahend table for the compare-subtract cells. No dependencies.
package dds_pkg;

	localparam int ValW      = 24;
	localparam int NumDigits = 6;
	localparam int DigitW    = 4;
	localparam int OutW      = 6;
	localparam int DigW      = NumDigits * DigitW;
	localparam int NumBlank  = NumDigits - 1;
	localparam int ModSteps  = 5;
	localparam int NumCells  = ModSteps + DigW;

	localparam logic [ValW-1:0] ModBase = 24'd1000000;
	localparam logic [OutW-1:0] BlankCode = 6'd10;
	localparam logic [OutW-1:0] AsciiZero = 6'd48;

	localparam logic [ValW-1:0] Place [NumDigits] = '{
		24'd100000, 24'd10000, 24'd1000, 24'd100, 24'd10, 24'd1
	};

	typedef enum logic [1:0] {
		ModePlain = 2'd0,
		ModeBlank = 2'd1,
		ModeAscii = 2'd2
	} dds_mode_t;

	localparam logic RegMode = 1'b0;

	typedef struct packed {
		logic [ValW-1:0]     rem;
		logic [DigW-1:0]     dig;
		logic [NumBlank-1:0] blank;
	} dds_pay_t;

	function automatic logic [ValW-1:0] sub_const(input int step);
		logic [ValW-1:0] base;
		int              sh;
		if (step < ModSteps) begin
			base = ModBase;
			sh   = ModSteps - 1 - step;
		end else begin
			base = Place[(step - ModSteps) >> 2];
			sh   = DigitW - 1 - ((step - ModSteps) & 3);
		end
		return base << sh;
	endfunction

endpackage

### design/dds_cell.sv
// One compare-subtract cell of the splitter chain with its output register.
// Depends on dds_pkg.
module dds_cell #(
	parameter int STEP = 0
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_vld,
	input  dds_pkg::dds_pay_t in_pay,
	output logic           out_vld,
	output dds_pkg::dds_pay_t out_pay
);
	import dds_pkg::*;

	localparam logic [ValW-1:0] Sub = sub_const(STEP);
	localparam bit HasBit = (STEP >= ModSteps);
	localparam int BitIdx = HasBit ? (DigW - 1 - (STEP - ModSteps)) : 0;

	logic     ge;
	dds_pay_t nxt;
	logic     vld_q;
	dds_pay_t pay_q;

	always_comb begin
		nxt = in_pay;
		ge  = (in_pay.rem >= Sub);
		if (ge) begin
			nxt.rem = in_pay.rem - Sub;
		end
		if (HasBit) begin
			nxt.dig[BitIdx] = ge;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		pay_q <= nxt;
	end

	assign out_vld = vld_q;
	assign out_pay = pay_q;

endmodule

### design/dds_enc.sv
// Output encoder of the splitter: plain, blanked or ASCII digits, registered.
// Depends on dds_pkg.
module dds_enc (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_vld,
	input  dds_pkg::dds_pay_t     in_pay,
	input  logic [1:0]            mode,
	output logic                  done,
	output logic [5:0]            digit_q [6]
);
	import dds_pkg::*;

	logic [OutW-1:0] enc [NumDigits];
	logic            done_q;

	always_comb begin
		logic [OutW-1:0] d;
		for (int i = 0; i < NumDigits; i++) begin
			d = {2'b00, in_pay.dig[DigW-1-DigitW*i -: DigitW]};
			case (mode)
				ModeBlank: begin
					if (i < NumBlank && in_pay.blank[i]) begin
						d = BlankCode;
					end
				end
				ModeAscii: begin
					d = d + AsciiZero;
				end
				default: begin
					d = d;
				end
			endcase
			enc[i] = d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		digit_q <= enc;
	end

	assign done = done_q;

endmodule

### design/decimal_digit_splitter.sv
// Top level of the six-digit decimal splitter: APB mode register, entry
// stage, chain of compare-subtract cells and output encoder.
// Depends on dds_pkg, dds_cell and dds_enc.
//
// Usage: pulse start with value; busy is always low, so a new transaction
// may be started in every cycle. Each transaction gives one result: done is
// high for exactly one cycle with the six digits, most significant first,
// of value modulo one million, and the receiver must take it then.
// Path: the entry stage, the 29 cells and the output register, in that order.
// Throughput: one transaction per cycle. The chain of 29 single-step cells
// sets the latency: five cells reduce modulo one million, then four cells
// per digit each test one quotient bit.
// digit_mode at APB byte address 0: 0 plain, 1 leading zeros blanked as
// code 10 while value is below that place, 2 ASCII, 3 as plain. Write it
// only while no transaction is in flight.
// Reset clears digit_mode to plain and drops every transaction in flight.
module decimal_digit_splitter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        start,
	output logic        busy,
	input  logic [23:0] value,
	output logic        done,
	output logic [5:0]  digit_hundred_thousands,
	output logic [5:0]  digit_ten_thousands,
	output logic [5:0]  digit_thousands,
	output logic [5:0]  digit_hundreds,
	output logic [5:0]  digit_tens,
	output logic [5:0]  digit_units
);
	import dds_pkg::*;

	logic [1:0]          digit_mode_q;
	logic                entry_vld_s0;
	dds_pay_t            entry_pay_s0;
	logic [NumBlank-1:0] blank;
	logic                chain_vld_s [NumCells+1];
	dds_pay_t            chain_pay_s [NumCells+1];
	logic [5:0]          digit_q [6];

	assign pready = 1'b1;
	assign busy   = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_mode_q <= ModePlain;
		end else if (psel && penable && pwrite && pready && paddr[2] == RegMode) begin
			digit_mode_q <= pwdata[1:0];
		end
	end

	assign prdata = (paddr[2] == RegMode) ? {30'd0, digit_mode_q} : 32'd0;

	always_comb begin
		for (int i = 0; i < NumBlank; i++) begin
			blank[i] = (value < Place[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_vld_s0 <= 1'b0;
		end else begin
			entry_vld_s0 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		entry_pay_s0.rem   <= value;
		entry_pay_s0.dig   <= '0;
		entry_pay_s0.blank <= blank;
	end

	assign chain_vld_s[0] = entry_vld_s0;
	assign chain_pay_s[0] = entry_pay_s0;

	for (genvar k = 0; k < NumCells; k++) begin : g_cell
		dds_cell #(
			.STEP(k)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.in_vld  (chain_vld_s[k]),
			.in_pay  (chain_pay_s[k]),
			.out_vld (chain_vld_s[k+1]),
			.out_pay (chain_pay_s[k+1])
		);
	end

	dds_enc u_enc (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (chain_vld_s[NumCells]),
		.in_pay  (chain_pay_s[NumCells]),
		.mode    (digit_mode_q),
		.done    (done),
		.digit_q (digit_q)
	);

	assign digit_hundred_thousands = digit_q[0];
	assign digit_ten_thousands     = digit_q[1];
	assign digit_thousands         = digit_q[2];
	assign digit_hundreds          = digit_q[3];
	assign digit_tens              = digit_q[4];
	assign digit_units             = digit_q[5];

`ifndef SYNTHESIS
	a_done_has_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 31))
		else $error("result without a matching transaction");

	a_plain_range: assert property (@(posedge clk) disable iff (!arst_n)
		done && digit_mode_q == ModePlain |->
			digit_hundred_thousands <= 6'd9 && digit_ten_thousands <= 6'd9 &&
			digit_thousands <= 6'd9 && digit_hundreds <= 6'd9 &&
			digit_tens <= 6'd9 && digit_units <= 6'd9)
		else $error("plain digit out of range");

	a_units_not_blank: assert property (@(posedge clk) disable iff (!arst_n)
		done && digit_mode_q == ModeBlank |-> digit_units <= 6'd9)
		else $error("units digit blanked");

	a_ascii_range: assert property (@(posedge clk) disable iff (!arst_n)
		done && digit_mode_q == ModeAscii |->
			digit_units >= 6'd48 && digit_units <= 6'd57 &&
			digit_hundred_thousands >= 6'd48 && digit_hundred_thousands <= 6'd57)
		else $error("ASCII digit out of range");
`endif

endmodule
